>>> rtl/jves_pkg.sv
// Package for the JSON value extent scanner: scan phases, result codes,
// character constants and byte classification functions. No dependencies.
package jves_pkg;

   localparam int unsigned POS_W   = 16;
   localparam int unsigned DEPTH_W = 16;

   // Position and depth limits, 65535 each (all ones of a 16-bit field).
   localparam logic [POS_W-1:0]   POS_LIMIT   = 16'hFFFF;
   localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = 16'hFFFF;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LC_B   = 8'h62;
   localparam logic [7:0] CH_LC_F   = 8'h66;
   localparam logic [7:0] CH_LC_N   = 8'h6E;
   localparam logic [7:0] CH_LC_R   = 8'h72;
   localparam logic [7:0] CH_LC_T   = 8'h74;

   typedef enum logic [2:0] {
      PH_BLANK   = 3'd0,
      PH_BRACKET = 3'd1,
      PH_STRING  = 3'd2,
      PH_LITERAL = 3'd3,
      PH_DONE    = 3'd4,
      PH_FAILED  = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ST_SCANNING      = 3'd0,
      ST_ENDS_AFTER    = 3'd1,
      ST_ENDED_BEFORE  = 3'd2,
      ST_FAILED        = 3'd3,
      ST_DONE_ALREADY  = 3'd4,
      ST_FAIL_ALREADY  = 3'd5
   } status_type;

   typedef struct packed {
      status_type       status;
      logic             in_value;
      logic [POS_W-1:0] value_begin;
      logic [POS_W-1:0] value_end;
      logic             last;
   } result_type;

   function automatic logic is_blank(input logic [7:0] b);
      return b inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
   endfunction

   function automatic logic ends_literal(input logic [7:0] b);
      return is_blank(b) || (b inside {CH_COMMA, CH_RBRACE, CH_RBRACK});
   endfunction

   function automatic logic valid_escape(input logic [7:0] b);
      return b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LC_B, CH_LC_F,
                       CH_LC_N, CH_LC_R, CH_LC_T};
   endfunction

endpackage

>>> rtl/jves_core.sv
// Scan state registers and the per-byte update logic of the scanner.
// Depends on jves_pkg.
module jves_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic [7:0]           text_byte,
   input  logic                 first_of_text,
   input  logic                 last_of_text,
   output jves_pkg::result_type result
);
   import jves_pkg::*;

   phase_type          phase_ff, phase_in;
   logic               escape_ff, escape_in;
   logic               inside_ff, inside_in;
   logic               kind_ff, kind_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   begin_ff, begin_in;

   // state as seen by this byte (a first mark clears it)
   phase_type          cur_phase;
   logic               cur_escape, cur_inside, cur_kind;
   logic [DEPTH_W-1:0] cur_depth;
   logic [POS_W-1:0]   cur_pos, cur_begin;

   logic       fail, str_fail, str_close, str_escape;
   logic [7:0] open_ch, close_ch;
   status_type status;
   logic       in_value;
   logic [POS_W-1:0] vend;

   always_comb begin
      cur_phase  = first_of_text ? PH_BLANK : phase_ff;
      cur_escape = first_of_text ? 1'b0 : escape_ff;
      cur_inside = first_of_text ? 1'b0 : inside_ff;
      cur_kind   = first_of_text ? 1'b0 : kind_ff;
      cur_depth  = first_of_text ? '0 : depth_ff;
      cur_pos    = first_of_text ? '0 : pos_ff;
      cur_begin  = first_of_text ? '0 : begin_ff;

      open_ch  = cur_kind ? CH_LBRACK : CH_LBRACE;
      close_ch = cur_kind ? CH_RBRACK : CH_RBRACE;

      // shared string byte handling
      str_fail   = 1'b0;
      str_close  = 1'b0;
      str_escape = cur_escape;
      if (cur_escape) begin
         if (valid_escape(text_byte)) str_escape = 1'b0;
         else                         str_fail = 1'b1;
      end else if (text_byte == CH_BSLASH) begin
         str_escape = 1'b1;
      end else if (text_byte == CH_QUOTE) begin
         str_close = 1'b1;
      end

      phase_in  = cur_phase;
      escape_in = cur_escape;
      inside_in = cur_inside;
      kind_in   = cur_kind;
      depth_in  = cur_depth;
      begin_in  = cur_begin;
      pos_in    = (cur_pos == POS_LIMIT) ? cur_pos : cur_pos + 1'b1;
      fail      = 1'b0;
      status    = ST_SCANNING;
      in_value  = 1'b0;
      vend      = '0;

      case (cur_phase)
         PH_DONE:   status = ST_DONE_ALREADY;
         PH_FAILED: status = ST_FAIL_ALREADY;
         default: begin
            if (cur_pos == POS_LIMIT) begin
               fail = 1'b1;
            end else begin
               case (cur_phase)
                  PH_BLANK: begin
                     if (is_blank(text_byte)) begin
                        fail = last_of_text;
                     end else begin
                        begin_in = cur_pos;
                        if (text_byte == CH_LBRACE || text_byte == CH_LBRACK) begin
                           phase_in = PH_BRACKET;
                           kind_in  = (text_byte == CH_LBRACK);
                           depth_in = {{(DEPTH_W-1){1'b0}}, 1'b1};
                           in_value = 1'b1;
                           fail     = last_of_text;
                        end else if (text_byte == CH_QUOTE) begin
                           phase_in  = PH_STRING;
                           inside_in = 1'b1;
                           in_value  = 1'b1;
                           fail      = last_of_text;
                        end else if (ends_literal(text_byte)) begin
                           // empty literal
                           status   = ST_ENDED_BEFORE;
                           vend     = cur_pos;
                           phase_in = PH_DONE;
                        end else begin
                           phase_in = PH_LITERAL;
                           in_value = 1'b1;
                           if (last_of_text) begin
                              status   = ST_ENDS_AFTER;
                              vend     = cur_pos + 1'b1;
                              phase_in = PH_DONE;
                           end
                        end
                     end
                  end
                  PH_LITERAL: begin
                     if (ends_literal(text_byte)) begin
                        status   = ST_ENDED_BEFORE;
                        vend     = cur_pos;
                        phase_in = PH_DONE;
                     end else begin
                        in_value = 1'b1;
                        if (last_of_text) begin
                           status   = ST_ENDS_AFTER;
                           vend     = cur_pos + 1'b1;
                           phase_in = PH_DONE;
                        end
                     end
                  end
                  PH_STRING: begin
                     in_value  = 1'b1;
                     escape_in = str_escape;
                     if (str_fail) begin
                        fail = 1'b1;
                     end else if (str_close) begin
                        inside_in = 1'b0;
                        status    = ST_ENDS_AFTER;
                        vend      = cur_pos + 1'b1;
                        phase_in  = PH_DONE;
                     end else begin
                        fail = last_of_text;
                     end
                  end
                  default: begin
                     // bracket phase
                     in_value = 1'b1;
                     if (cur_inside) begin
                        escape_in = str_escape;
                        if (str_fail) fail = 1'b1;
                        else if (str_close) inside_in = 1'b0;
                     end else if (text_byte == CH_QUOTE) begin
                        inside_in = 1'b1;
                     end else if (text_byte == open_ch) begin
                        if (cur_depth == DEPTH_LIMIT) fail = 1'b1;
                        else depth_in = cur_depth + 1'b1;
                     end else if (text_byte == close_ch) begin
                        depth_in = cur_depth - 1'b1;
                        if (depth_in == '0) begin
                           status   = ST_ENDS_AFTER;
                           vend     = cur_pos + 1'b1;
                           phase_in = PH_DONE;
                        end
                     end
                     if (!fail && phase_in == PH_BRACKET && last_of_text) fail = 1'b1;
                  end
               endcase
            end
         end
      endcase

      if (fail) begin
         status    = ST_FAILED;
         in_value  = 1'b0;
         phase_in  = PH_FAILED;
         escape_in = 1'b0;
         inside_in = 1'b0;
      end

      result.status   = status;
      result.in_value = in_value;
      result.last     = last_of_text;
      if (status == ST_ENDS_AFTER || status == ST_ENDED_BEFORE) begin
         result.value_begin = begin_in;
         result.value_end   = vend;
      end else begin
         result.value_begin = '0;
         result.value_end   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_BLANK;
         escape_ff <= 1'b0;
         inside_ff <= 1'b0;
         kind_ff   <= 1'b0;
         depth_ff  <= '0;
         pos_ff    <= '0;
         begin_ff  <= '0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         escape_ff <= escape_in;
         inside_ff <= inside_in;
         kind_ff   <= kind_in;
         depth_ff  <= depth_in;
         pos_ff    <= pos_in;
         begin_ff  <= begin_in;
      end
   end

`ifndef SYNTHESIS
   // an escape can only be pending inside a string
   a_escape_in_string: assert property (@(posedge clock) disable iff (reset)
      escape_ff |-> (inside_ff || phase_ff == PH_STRING))
      else $error("escape pending outside a string");

   // an open bracket value always has a nonzero depth
   a_depth_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BRACKET) |-> (depth_ff != '0))
      else $error("bracket phase with zero depth");

   // position never moves back except on a first mark
   a_pos_monotonic: assert property (@(posedge clock) disable iff (reset)
      (step_en && !first_of_text) |=> (pos_ff >= $past(pos_ff)))
      else $error("byte position moved back");
`endif

endmodule

>>> rtl/json_value_extent_scanner_top.sv
// Top level of the JSON value extent scanner: input register, scan core and
// result register with stream handshakes. Depends on jves_pkg and jves_core.
//
// Usage: the text is streamed one byte per item on the req_ channel. tuser
// marks the first byte of a text (restarts the scan at position 0), tlast the
// final byte. Every accepted byte yields exactly one item on the rsp_ channel,
// carrying the scan status, whether the byte lies inside the value, and the
// value's begin and end positions once the value is closed.
// Pipeline: an accepted byte is held in the input register and its result
// is registered in the result register (two register stages: input register,
// then result register). Throughput: one item per cycle sustained while
// rsp_tready stays high; all scan state (phase, depth, position, string/escape
// flags) updates together for each byte. Stalls: when rsp_tready is low the
// result register holds; the input register still takes one more byte, then
// req_tready drops until the result is taken. No item is lost or repeated.
// Reset (synchronous, active high) empties both stages and returns the scan
// to the leading whitespace phase at position 0.
module json_value_extent_scanner_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tuser,   // [0] first_of_text
   input  logic        req_tlast,   // last_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [2:0] scan_status, [3] byte_in_value,
                                    // [19:4] value_begin, [35:20] value_end,
                                    // [39:36] zero
   output logic        rsp_tlast    // last_result
);
   import jves_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_first_ff, in_last_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type core_result;
   logic       advance, step, req_take;

   // result stage can move when empty or being drained
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_tdata;
         in_first_ff <= req_tuser;
         in_last_ff  <= req_tlast;
      end
      if (step) rsp_ff <= core_result;
   end

   jves_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step_en       (step),
      .text_byte     (in_byte_ff),
      .first_of_text (in_first_ff),
      .last_of_text  (in_last_ff),
      .result        (core_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {4'b0000, rsp_ff.value_end, rsp_ff.value_begin,
                        rsp_ff.in_value, rsp_ff.status};

`ifndef SYNTHESIS
   // a closed value never ends before it begins
   a_extent_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == ST_ENDS_AFTER ||
                        rsp_ff.status == ST_ENDED_BEFORE))
      |-> (rsp_ff.value_end >= rsp_ff.value_begin))
      else $error("value end before value begin");

   // only a scanning or closing byte can be part of the value
   a_in_value_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.in_value)
      |-> (rsp_ff.status == ST_SCANNING || rsp_ff.status == ST_ENDS_AFTER))
      else $error("byte in value with wrong status");

   // positions are zero unless a value is reported
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != ST_ENDS_AFTER &&
       rsp_ff.status != ST_ENDED_BEFORE)
      |-> (rsp_ff.value_begin == '0 && rsp_ff.value_end == '0))
      else $error("positions set without a value");

   // a held input item stays until the result stage frees up
   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("input item dropped while stalled");
`endif

endmodule
